// ===== sv/crt_pkg.sv =====
// Shared types and constants of the command retry table.
// Used by the configuration registers, the control and the top level.
package crt_pkg;

  localparam int QUEUE_DEPTH   = 8;
  localparam int IDX_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OUT_IDX_W     = 3;
  localparam int MAX_FRAME_LEN = 32;
  localparam logic [7:0] NO_SLOT = 8'hFF;

  localparam logic [31:0] TTL_RESET          = 32'd10000;
  localparam logic [7:0]  MAX_HOPS_RESET     = 8'd5;
  localparam logic [31:0] HOP_INTERVAL_RESET = 32'd500;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TTL          = 2'd0,
    REG_MAX_HOPS     = 2'd1,
    REG_HOP_INTERVAL = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_ENQUEUE = 1'b0,
    REQ_TICK    = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    EV_ACCEPTED  = 3'd0,
    EV_REJECTED  = 3'd1,
    EV_EVICTED   = 3'd2,
    EV_SEND      = 3'd3,
    EV_DROP_TTL  = 3'd4,
    EV_DROP_HOPS = 3'd5,
    EV_DONE      = 3'd6
  } event_kind_t;

  typedef struct packed {
    logic [31:0] ttl_ms;
    logic [7:0]  max_hops;
    logic [31:0] hop_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [47:0] dest;
    logic        bcast;
    logic [7:0]  slot;
    logic [7:0]  frame;
    logic [7:0]  len;
    logic [7:0]  hops;
    logic [31:0] created;
    logic [31:0] next_retry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/crt_in_if.sv =====
// Input request channel of the command retry table.
// Valid/ready handshake; payload widths follow the request fields.
interface crt_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [31:0]       now_time;
  logic [47:0]       dest_addr;
  logic              bcast_flag;
  logic signed [8:0] sensor_slot;
  logic [7:0]        frame_handle;
  logic [7:0]        frame_len;

  modport source (
    output valid, req_type, now_time, dest_addr, bcast_flag, sensor_slot,
           frame_handle, frame_len,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_time, dest_addr, bcast_flag, sensor_slot,
           frame_handle, frame_len,
    output ready
  );
endinterface

// ===== sv/crt_out_if.sv =====
// Result channel of the command retry table.
// Valid/ready handshake; one event word per handshake.
interface crt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [2:0]  entry_index;
  logic [47:0] out_dest;
  logic        out_bcast;
  logic [7:0]  out_slot;
  logic [7:0]  out_frame;
  logic [7:0]  out_len;
  logic [7:0]  hop_count;
  logic        last;

  modport source (
    output valid, event_kind, entry_index, out_dest, out_bcast, out_slot,
           out_frame, out_len, hop_count, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, entry_index, out_dest, out_bcast, out_slot,
           out_frame, out_len, hop_count, last,
    output ready
  );
endinterface

// ===== sv/crt_cfg_if.sv =====
// Configuration write channel of the command retry table.
// Carries a register index and write data under valid/ready.
interface crt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/command_retry_table.sv =====
// Command retry table top level: configuration registers, sequencer, entry memory.
// An enqueue into a free entry passes the accept and done states; one into a full
// table first searches the 8 entries for the oldest and evicts it. A tick reads
// the 8 entries, one memory read per cycle on the single read port, while the
// result side does not stall. One request at a time. Reset clears all entries'
// active bits and loads the register defaults; no memory clearing pass is needed.
module command_retry_table (
  input  logic       clk,
  input  logic       rst_n,
  crt_in_if.sink     in_ch,
  crt_out_if.source  out_ch,
  crt_cfg_if.sink    cfg_ch
);

  crt_pkg::cfg_t                cfg;
  logic                         ram_wr_en;
  logic [crt_pkg::IDX_W-1:0]    ram_wr_addr;
  crt_pkg::entry_t              ram_wr_data;
  logic                         ram_rd_en;
  logic [crt_pkg::IDX_W-1:0]    ram_rd_addr;
  crt_pkg::entry_t              ram_rd_data;

  crt_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  crt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg         (cfg),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  crt_ram #(
    .WIDTH (crt_pkg::ENTRY_W),
    .DEPTH (crt_pkg::QUEUE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

// ===== sv/crt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is issued. No package dependency.
module crt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/crt_cfg_regs.sv =====
// Configuration registers of the command retry table: TTL, hop limit, hop interval.
// Depends on crt_pkg and crt_cfg_if.
module crt_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  crt_cfg_if.sink       cfg_ch,
  output crt_pkg::cfg_t cfg
);

  crt_pkg::cfg_t cfg_r;
  crt_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (crt_pkg::cfg_reg_t'(cfg_ch.index))
        crt_pkg::REG_TTL:          cfg_nxt.ttl_ms = cfg_ch.data;
        crt_pkg::REG_MAX_HOPS:     cfg_nxt.max_hops = cfg_ch.data[7:0];
        crt_pkg::REG_HOP_INTERVAL: cfg_nxt.hop_interval_ms = cfg_ch.data;
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ttl_ms          <= crt_pkg::TTL_RESET;
      cfg_r.max_hops        <= crt_pkg::MAX_HOPS_RESET;
      cfg_r.hop_interval_ms <= crt_pkg::HOP_INTERVAL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/crt_ctrl.sv =====
// Sequencer of the command retry table: accepts requests, walks the entry memory
// one entry per cycle while a tick is not stalled, writes back updated entries and
// registers each event word. Depends on crt_pkg, crt_in_if and crt_out_if.
module crt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  crt_in_if.sink                      in_ch,
  crt_out_if.source                   out_ch,
  input  crt_pkg::cfg_t               cfg,
  output logic                        ram_wr_en,
  output logic [crt_pkg::IDX_W-1:0]   ram_wr_addr,
  output crt_pkg::entry_t             ram_wr_data,
  output logic                        ram_rd_en,
  output logic [crt_pkg::IDX_W-1:0]   ram_rd_addr,
  input  crt_pkg::entry_t             ram_rd_data
);

  localparam int IDX_W = crt_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(crt_pkg::QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_ACCEPT,
    ST_REJECT,
    ST_DONE
  } state_t;

  typedef struct packed {
    crt_pkg::event_kind_t           kind;
    logic [crt_pkg::OUT_IDX_W-1:0]  idx;
    logic [47:0]                    dest;
    logic                           bcast;
    logic [7:0]                     slot;
    logic [7:0]                     frame;
    logic [7:0]                     len;
    logic [7:0]                     hops;
    logic                           last;
  } res_t;

  state_t                          state_r, state_nxt;
  logic [crt_pkg::QUEUE_DEPTH-1:0] active_r, active_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic [IDX_W-1:0]                best_idx_r, best_idx_nxt;
  logic [31:0]                     best_age_r, best_age_nxt;
  logic [IDX_W-1:0]                target_r, target_nxt;
  crt_pkg::req_type_t              req_r, req_nxt;
  logic [31:0]                     now_r, now_nxt;
  crt_pkg::entry_t                 new_r, new_nxt;
  logic                            out_valid_r, out_valid_nxt;
  res_t                            res_r, res_nxt;

  logic             any_free;
  logic [IDX_W-1:0] first_free;

  // Lowest free entry.
  always_comb begin
    any_free   = 1'b0;
    first_free = '0;
    for (int i = crt_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        any_free   = 1'b1;
        first_free = IDX_W'(i);
      end
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    logic        out_free;
    logic [31:0] age;
    logic [31:0] since_retry;
    logic        act;
    logic        drop_ttl;
    logic        drop_hops;
    logic        due;
    logic        emit;
    logic        bad_len;

    state_nxt     = state_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    best_idx_nxt  = best_idx_r;
    best_age_nxt  = best_age_r;
    target_nxt    = target_r;
    req_nxt       = req_r;
    now_nxt       = now_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;

    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_data = ram_rd_data;

    out_free = !out_valid_r || out_ch.ready;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    age         = now_r - ram_rd_data.created;
    since_retry = now_r - ram_rd_data.next_retry;
    act         = active_r[idx_r];
    drop_ttl    = age > cfg.ttl_ms;
    drop_hops   = ram_rd_data.hops >= cfg.max_hops;
    due         = !since_retry[31];
    emit        = act && (drop_ttl || drop_hops || due);
    bad_len     = (in_ch.frame_len == 8'd0) ||
                  (in_ch.frame_len > 8'(crt_pkg::MAX_FRAME_LEN));

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt            = crt_pkg::req_type_t'(in_ch.req_type);
          now_nxt            = in_ch.now_time;
          new_nxt.dest       = in_ch.dest_addr;
          new_nxt.bcast      = in_ch.bcast_flag;
          new_nxt.slot       = in_ch.sensor_slot[8] ? crt_pkg::NO_SLOT
                                                    : in_ch.sensor_slot[7:0];
          new_nxt.frame      = in_ch.frame_handle;
          new_nxt.len        = in_ch.frame_len;
          new_nxt.hops       = 8'd0;
          new_nxt.created    = in_ch.now_time;
          new_nxt.next_retry = in_ch.now_time;
          idx_nxt            = '0;
          if (crt_pkg::req_type_t'(in_ch.req_type) == crt_pkg::REQ_TICK) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_nxt   = ST_SCAN;
          end else if (bad_len) begin
            state_nxt = ST_REJECT;
          end else if (any_free) begin
            target_nxt = first_free;
            state_nxt  = ST_ACCEPT;
          end else begin
            // full table: search for the oldest entry
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (req_r == crt_pkg::REQ_TICK) begin
          // stall on a busy output; read data holds while no read is issued
          if (!emit || out_free) begin
            if (emit) begin
              out_valid_nxt = 1'b1;
              res_nxt.idx   = crt_pkg::OUT_IDX_W'(idx_r);
              res_nxt.dest  = ram_rd_data.dest;
              res_nxt.bcast = ram_rd_data.bcast;
              res_nxt.slot  = ram_rd_data.slot;
              res_nxt.frame = ram_rd_data.frame;
              res_nxt.len   = ram_rd_data.len;
              res_nxt.hops  = ram_rd_data.hops;
              res_nxt.last  = 1'b0;
              if (drop_ttl) begin
                res_nxt.kind       = crt_pkg::EV_DROP_TTL;
                active_nxt[idx_r]  = 1'b0;
              end else if (drop_hops) begin
                res_nxt.kind       = crt_pkg::EV_DROP_HOPS;
                active_nxt[idx_r]  = 1'b0;
              end else begin
                res_nxt.kind           = crt_pkg::EV_SEND;
                res_nxt.hops           = ram_rd_data.hops + 8'd1;
                ram_wr_en              = 1'b1;
                ram_wr_addr            = idx_r;
                ram_wr_data.hops       = ram_rd_data.hops + 8'd1;
                ram_wr_data.next_retry = now_r + cfg.hop_interval_ms;
              end
            end
            if (idx_r == LAST_IDX) begin
              state_nxt = ST_DONE;
            end else begin
              idx_nxt     = idx_r + 1'b1;
              ram_rd_en   = 1'b1;
              ram_rd_addr = idx_r + 1'b1;
            end
          end
        end else begin
          if (idx_r == '0 || age > best_age_r) begin
            best_age_nxt = age;
            best_idx_nxt = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = best_idx_nxt;
            target_nxt  = best_idx_nxt;
            state_nxt   = ST_EVICT;
          end else begin
            idx_nxt     = idx_r + 1'b1;
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_r + 1'b1;
          end
        end
      end

      ST_EVICT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_nxt.kind  = crt_pkg::EV_EVICTED;
          res_nxt.idx   = crt_pkg::OUT_IDX_W'(target_r);
          res_nxt.dest  = ram_rd_data.dest;
          res_nxt.bcast = ram_rd_data.bcast;
          res_nxt.slot  = ram_rd_data.slot;
          res_nxt.frame = ram_rd_data.frame;
          res_nxt.len   = ram_rd_data.len;
          res_nxt.hops  = ram_rd_data.hops;
          res_nxt.last  = 1'b0;
          state_nxt     = ST_ACCEPT;
        end
      end

      ST_ACCEPT: begin
        if (out_free) begin
          ram_wr_en            = 1'b1;
          ram_wr_addr          = target_r;
          ram_wr_data          = new_r;
          active_nxt[target_r] = 1'b1;
          out_valid_nxt        = 1'b1;
          res_nxt.kind         = crt_pkg::EV_ACCEPTED;
          res_nxt.idx          = crt_pkg::OUT_IDX_W'(target_r);
          res_nxt.dest         = new_r.dest;
          res_nxt.bcast        = new_r.bcast;
          res_nxt.slot         = new_r.slot;
          res_nxt.frame        = new_r.frame;
          res_nxt.len          = new_r.len;
          res_nxt.hops         = 8'd0;
          res_nxt.last         = 1'b0;
          state_nxt            = ST_DONE;
        end
      end

      ST_REJECT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_nxt.kind  = crt_pkg::EV_REJECTED;
          res_nxt.idx   = '0;
          res_nxt.dest  = new_r.dest;
          res_nxt.bcast = new_r.bcast;
          res_nxt.slot  = new_r.slot;
          res_nxt.frame = new_r.frame;
          res_nxt.len   = new_r.len;
          res_nxt.hops  = 8'd0;
          res_nxt.last  = 1'b0;
          state_nxt     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          res_nxt.kind  = crt_pkg::EV_DONE;
          res_nxt.last  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_age_r <= best_age_nxt;
    target_r   <= target_nxt;
    req_r      <= req_nxt;
    now_r      <= now_nxt;
    new_r      <= new_nxt;
    res_r      <= res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = res_r.kind;
  assign out_ch.entry_index = res_r.idx;
  assign out_ch.out_dest    = res_r.dest;
  assign out_ch.out_bcast   = res_r.bcast;
  assign out_ch.out_slot    = res_r.slot;
  assign out_ch.out_frame   = res_r.frame;
  assign out_ch.out_len     = res_r.len;
  assign out_ch.hop_count   = res_r.hops;
  assign out_ch.last        = res_r.last;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of command_retry_table: a scoreboard class predicts every event word
// from each accepted request, and plain tasks drive the request and register write channels.
// Depends on crt_pkg, the three channel interfaces and the command_retry_table top level.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REG_SPARE = 2'd3;  // no register behind this index

  typedef struct packed {
    crt_pkg::req_type_t kind;
    logic [31:0]        now;
    logic [47:0]        dest;
    logic               bcast;
    logic signed [8:0]  slot;
    logic [7:0]         frame;
    logic [7:0]         len;
  } request_t;

  typedef struct packed {
    crt_pkg::event_kind_t kind;
    logic [2:0]           index;
    logic [47:0]          dest;
    logic                 bcast;
    logic [7:0]           slot;
    logic [7:0]           frame;
    logic [7:0]           len;
    logic [7:0]           hops;
    logic                 last;
  } event_word_t;

  typedef struct {
    logic [31:0] ttl;
    logic [7:0]  hops;
    logic [31:0] interval;
    int unsigned step_max;
    int          items;
    int          enq_pct;
    logic [31:0] start;
  } phase_t;

  class retry_table_checker;
    logic [31:0]      ttl_ms;
    logic [7:0]       max_hops;
    logic [31:0]      hop_interval;
    bit               active[crt_pkg::QUEUE_DEPTH];
    crt_pkg::entry_t  entries[crt_pkg::QUEUE_DEPTH];
    event_word_t      expected_events[$];
    int               mismatches;
    int               words_checked;
    int               n_requests;
    int               n_sends;
    int               n_evictions;
    int               n_drops;

    function new();
      ttl_ms       = crt_pkg::TTL_RESET;
      max_hops     = crt_pkg::MAX_HOPS_RESET;
      hop_interval = crt_pkg::HOP_INTERVAL_RESET;
      foreach (active[i]) active[i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        crt_pkg::REG_TTL:          ttl_ms       = value;
        crt_pkg::REG_MAX_HOPS:     max_hops     = value[7:0];
        crt_pkg::REG_HOP_INTERVAL: hop_interval = value;
        default: ;  // unmapped index: drop the write
      endcase
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function event_word_t entry_word(crt_pkg::event_kind_t kind, int i);
      event_word_t w;
      w.kind  = kind;
      w.index = 3'(i);
      w.dest  = entries[i].dest;
      w.bcast = entries[i].bcast;
      w.slot  = entries[i].slot;
      w.frame = entries[i].frame;
      w.len   = entries[i].len;
      w.hops  = entries[i].hops;
      w.last  = 1'b0;
      return w;
    endfunction

    function void note_request(request_t r);
      event_word_t w;
      logic [7:0]  stored_slot;
      logic [31:0] age;
      logic [31:0] oldest_age;
      logic [31:0] retry_gap;
      int          target;
      n_requests++;
      if (r.kind == crt_pkg::REQ_ENQUEUE) begin
        stored_slot = r.slot[8] ? crt_pkg::NO_SLOT : r.slot[7:0];
        if (r.len == 8'd0 || r.len > 8'(crt_pkg::MAX_FRAME_LEN)) begin
          w = '{crt_pkg::EV_REJECTED, 3'd0, r.dest, r.bcast, stored_slot, r.frame,
                r.len, 8'd0, 1'b0};
          expected_events.push_back(w);
        end else begin
          target = -1;
          for (int i = 0; i < crt_pkg::QUEUE_DEPTH; i++) begin
            if (!active[i] && target < 0) target = i;
          end
          if (target < 0) begin
            // full: evict the greatest age, lowest index on a tie
            target = 0;
            oldest_age = r.now - entries[0].created;
            for (int i = 1; i < crt_pkg::QUEUE_DEPTH; i++) begin
              age = r.now - entries[i].created;
              if (age > oldest_age) begin
                oldest_age = age;
                target = i;
              end
            end
            expected_events.push_back(entry_word(crt_pkg::EV_EVICTED, target));
            n_evictions++;
          end
          active[target] = 1'b1;
          entries[target] = '{r.dest, r.bcast, stored_slot, r.frame, r.len, 8'd0,
                              r.now, r.now};
          expected_events.push_back(entry_word(crt_pkg::EV_ACCEPTED, target));
        end
      end else begin
        for (int i = 0; i < crt_pkg::QUEUE_DEPTH; i++) begin
          if (active[i]) begin
            age = r.now - entries[i].created;
            retry_gap = r.now - entries[i].next_retry;
            if (age > ttl_ms) begin
              active[i] = 1'b0;
              expected_events.push_back(entry_word(crt_pkg::EV_DROP_TTL, i));
              n_drops++;
            end else if (entries[i].hops >= max_hops) begin
              active[i] = 1'b0;
              expected_events.push_back(entry_word(crt_pkg::EV_DROP_HOPS, i));
              n_drops++;
            end else if (!retry_gap[31]) begin
              entries[i].hops = entries[i].hops + 8'd1;
              entries[i].next_retry = r.now + hop_interval;
              expected_events.push_back(entry_word(crt_pkg::EV_SEND, i));
              n_sends++;
            end
          end
        end
      end
      w = '{crt_pkg::EV_DONE, 3'd0, 48'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
      expected_events.push_back(w);
    endfunction

    function void compare_field(string name, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_event(event_word_t got);
      event_word_t want;
      if (expected_events.size() == 0) begin
        $error("event word with nothing outstanding: kind %0d index %0d", got.kind, got.index);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      words_checked++;
      compare_field("event_kind",  want.kind,  got.kind);
      compare_field("entry_index", want.index, got.index);
      compare_field("out_dest",    want.dest,  got.dest);
      compare_field("out_bcast",   want.bcast, got.bcast);
      compare_field("out_slot",    want.slot,  got.slot);
      compare_field("out_frame",   want.frame, got.frame);
      compare_field("out_len",     want.len,   got.len);
      compare_field("hop_count",   want.hops,  got.hops);
      compare_field("last",        want.last,  got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  crt_in_if  in_if();
  crt_out_if out_if();
  crt_cfg_if cfg_if();

  command_retry_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  retry_table_checker rt_sb;
  logic [31:0]        now_ms;
  int                 burst_left;
  int                 settings_used;
  int                 stall_left;
  int                 stall_style;
  int                 style_left;

  always #4 clk = ~clk;

  task automatic push_request(input request_t r);
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.req_type     <= r.kind;
    in_if.now_time     <= r.now;
    in_if.dest_addr    <= r.dest;
    in_if.bcast_flag   <= r.bcast;
    in_if.sensor_slot  <= r.slot;
    in_if.frame_handle <= r.frame;
    in_if.frame_len    <= r.len;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    rt_sb.note_request(r);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic enqueue(input logic [31:0] t, input logic [47:0] dest, input logic bcast,
                         input logic [8:0] slot, input logic [7:0] frame,
                         input logic [7:0] len);
    push_request('{crt_pkg::REQ_ENQUEUE, t, dest, bcast, slot, frame, len});
  endtask

  task automatic tick(input logic [31:0] t);
    push_request('{crt_pkg::REQ_TICK, t, 48'($urandom), 1'b0, 9'd0, 8'd0, 8'd0});
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    rt_sb.set_reg(idx, value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (rt_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic request_t random_request(input int enq_pct);
    request_t r;
    r.kind = ($urandom_range(0, 99) < enq_pct) ? crt_pkg::REQ_ENQUEUE
                                               : crt_pkg::REQ_TICK;
    r.now  = now_ms;
    case ($urandom_range(0, 9))
      0:       r.dest = '0;
      1:       r.dest = '1;
      default: r.dest = {16'($urandom), 32'($urandom)};
    endcase
    r.bcast = 1'($urandom);
    r.slot  = 9'($urandom_range(0, 511));
    r.len   = ($urandom_range(0, 9) < 8)
              ? 8'($urandom_range(1, crt_pkg::MAX_FRAME_LEN))
              : 8'($urandom_range(0, 255));
    return r;
  endfunction

  // receiver: switch between always ready, coin flips and stall runs
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left  = $urandom_range(20, 200);
    end else begin
      style_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (stall_style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom);
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15);
            out_if.ready <= 1'b0;
          end else begin
            out_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      rt_sb.check_event('{crt_pkg::event_kind_t'(out_if.event_kind), out_if.entry_index,
                          out_if.out_dest, out_if.out_bcast, out_if.out_slot,
                          out_if.out_frame, out_if.out_len, out_if.hop_count,
                          out_if.last});
    end
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    phase_t    phases[6];
    request_t  r;
    logic [31:0] t0;
    logic [31:0] t1;
    clk            = 1'b0;
    rst_n          = 1'b0;
    stall_left     = 0;
    stall_style    = 0;
    style_left     = 0;
    burst_left     = 0;
    settings_used  = 1;
    rt_sb          = new();
    in_if.valid        = 1'b0;
    in_if.req_type     = crt_pkg::REQ_TICK;
    in_if.now_time     = '0;
    in_if.dest_addr    = '0;
    in_if.bcast_flag   = 1'b0;
    in_if.sensor_slot  = '0;
    in_if.frame_handle = '0;
    in_if.frame_len    = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = crt_pkg::REG_TTL;
    cfg_if.data        = '0;

    phases[0] = '{32'd10000,     8'd5,   32'd500,         400,        80, 45, 32'd40000};
    phases[1] = '{32'hFFFF_FFFF, 8'd255, 32'd0,           50,         50, 40, 32'd90000};
    phases[2] = '{32'd0,         8'd1,   32'hFFFF_FFFF,   3,          40, 50, 32'd100};
    phases[3] = '{32'd2500,      8'd3,   32'd300,         250,        60, 45, 32'hFFFF_F800};
    phases[4] = '{32'd1500,      8'd0,   32'd100,         200,        25, 50, 32'd5000};
    phases[5] = '{32'h8000_0000, 8'd2,   32'h8000_0000,   32'h4000_0000, 40, 45, 32'd0};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // rejected lengths echo the request; a negative slot is stored as none
    t0 = 32'd1000;
    enqueue(t0, 48'h0, 1'b0, 9'd0, 8'h00, 8'd0);
    enqueue(t0, '1, 1'b1, 9'h1FF, 8'hFF, 8'd33);
    enqueue(t0, 48'hA5A5_5A5A_C3C3, 1'b0, 9'h100, 8'h5A, 8'd255);
    // fill the table; entries 0 and 1 share a creation time
    enqueue(t0, '1, 1'b1, 9'h1FF, 8'hFF, 8'd32);
    enqueue(t0, 48'h0, 1'b0, 9'd0, 8'h00, 8'd1);
    for (int k = 2; k < crt_pkg::QUEUE_DEPTH; k++) begin
      enqueue(t0 + k, {16'($urandom), 32'($urandom)}, 1'(k), (k == 2) ? 9'd254 : 9'h0FF,
              8'(k * 37), 8'(k * 4));
    end
    // full table: tie goes to entry 0, then entry 1 is the oldest
    enqueue(t0 + 10, 48'h1234_5678_9ABC, 1'b1, 9'd17, 8'h81, 8'd16);
    enqueue(t0 + 11, 48'hFEDC_BA98_7654, 1'b0, 9'h1F0, 8'h7E, 8'd2);
    t1 = t0 + 11;
    tick(t1);
    tick(t1 + 499);
    tick(t1 + 500);
    tick(t1 + 11000);
    // one entry sent until its hops run out
    t1 = t0 + 20000;
    enqueue(t1, 48'h0000_FFFF_0000, 1'b1, 9'd3, 8'h33, 8'd8);
    for (int k = 0; k < 6; k++) tick(t1 + k * 500);

    foreach (phases[p]) begin
      pause_sender(1);
      wait_idle();
      if (p == 5) write_reg(REG_SPARE, 32'hDEAD_BEEF);
      write_reg(crt_pkg::REG_TTL, phases[p].ttl);
      write_reg(crt_pkg::REG_MAX_HOPS, {24'd0, phases[p].hops});
      write_reg(crt_pkg::REG_HOP_INTERVAL, phases[p].interval);
      settings_used++;
      now_ms = phases[p].start;
      for (int n = 0; n < phases[p].items; n++) begin
        if (burst_left == 0) begin
          pause_sender($urandom_range(1, 12));
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
        end
        burst_left--;
        // advance time; now and then jump anywhere on the clock
        if ($urandom_range(0, 49) == 0) now_ms = $urandom;
        else now_ms = now_ms + $urandom_range(0, phases[p].step_max);
        r = random_request(phases[p].enq_pct);
        push_request(r);
      end
    end

    pause_sender(1);
    wait_idle();
    repeat (30) @(posedge clk);

    $display("Ran %0d requests under %0d register settings; %0d event words checked",
             rt_sb.n_requests, settings_used, rt_sb.words_checked);
    $display("Sends %0d, evictions %0d, drops %0d, mismatches %0d",
             rt_sb.n_sends, rt_sb.n_evictions, rt_sb.n_drops, rt_sb.mismatches);
    if (rt_sb.mismatches == 0 && rt_sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
